@@ rtl/xtea_pkg.sv @@
// XTEA block cipher: shared constants, types and the round mixing function.
// No dependencies; used by xtea_stage and xtea_block_cipher.
package xtea_pkg;

    localparam int unsigned  CycleCount = 64;
    localparam int unsigned  WordW      = 32;
    localparam int unsigned  KeyWords   = 4;
    localparam int unsigned  KeyIdxW    = 2;
    localparam logic [31:0]  XteaDelta  = 32'h9E37_79B9;

    localparam logic         OpEncrypt  = 1'b0;
    localparam logic         OpDecrypt  = 1'b1;

    typedef logic [KeyWords-1:0][WordW-1:0] t_key;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic [WordW-1:0] first;
        logic [WordW-1:0] second;
    } t_stage;

    function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

@@ rtl/xtea_stage.sv @@
// XTEA pipeline stage: one Feistel half-round followed by the stage register.
// Round sum and key index are fixed per stage position. Depends on xtea_pkg.
module xtea_stage #(
    parameter int unsigned STEP        = 0,
    parameter int unsigned CYCLE_COUNT = xtea_pkg::CycleCount
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  xtea_pkg::t_key      i_key,
    input  xtea_pkg::t_stage    i_stage,
    output xtea_pkg::t_stage    o_stage
);

    localparam bit          IsOdd  = (STEP % 2) == 1;
    localparam int unsigned Rounds = (STEP + 1) / 2;
    localparam logic [31:0] EncSum = xtea_pkg::XteaDelta * 32'(Rounds);
    localparam logic [31:0] DecSum = xtea_pkg::XteaDelta * 32'(CYCLE_COUNT - Rounds);
    localparam logic [xtea_pkg::KeyIdxW-1:0] EncIdx = IsOdd ? EncSum[12:11] : EncSum[1:0];
    localparam logic [xtea_pkg::KeyIdxW-1:0] DecIdx = IsOdd ? DecSum[1:0] : DecSum[12:11];

    xtea_pkg::t_stage r_stage;
    xtea_pkg::t_stage n_stage;

    logic                          w_dec;
    logic                          w_upd_first;
    logic [xtea_pkg::WordW-1:0]    w_src;
    logic [xtea_pkg::WordW-1:0]    w_dst;
    logic [xtea_pkg::WordW-1:0]    w_key_sum;
    logic [xtea_pkg::WordW-1:0]    w_f;
    logic [xtea_pkg::WordW-1:0]    w_res;

    always_comb begin
        w_dec       = (i_stage.op == xtea_pkg::OpDecrypt);
        // encrypt updates first on even steps, decrypt on odd steps
        w_upd_first = w_dec ? IsOdd : !IsOdd;
        w_src       = w_upd_first ? i_stage.second : i_stage.first;
        w_dst       = w_upd_first ? i_stage.first  : i_stage.second;
        w_key_sum   = w_dec ? (DecSum + i_key[DecIdx]) : (EncSum + i_key[EncIdx]);
        w_f         = xtea_pkg::mix(w_src) ^ w_key_sum;
        w_res       = w_dec ? (w_dst - w_f) : (w_dst + w_f);

        n_stage     = i_stage;
        if (w_upd_first) begin
            n_stage.first = w_res;
        end else begin
            n_stage.second = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/xtea_block_cipher.sv @@
// XTEA block cipher top level: key registers, half-round pipeline, output buffer.
// Depends on xtea_pkg and xtea_stage.

// The block enciphers (op 0) or deciphers (op 1) one 64-bit block per transfer
// with XTEA over CYCLE_COUNT XTEA double rounds under the 128-bit key in registers 0..3.
// Each half-round is one pipeline stage, followed at the end by the output register,
// and a new block is taken every cycle unless the input is stalled. The output
// register and a one-entry skid buffer hold results while the output is stalled;
// the input stalls only once the skid entry is full. Key writes must happen while
// the pipeline is empty.
module xtea_block_cipher #(
    parameter int unsigned CYCLE_COUNT = xtea_pkg::CycleCount
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [xtea_pkg::KeyIdxW-1:0]       i_cfg_index,
    input  logic [xtea_pkg::WordW-1:0]         i_cfg_data,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic [xtea_pkg::WordW-1:0]         i_block_first,
    input  logic [xtea_pkg::WordW-1:0]         i_block_second,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [xtea_pkg::WordW-1:0]         o_result_first,
    output logic [xtea_pkg::WordW-1:0]         o_result_second
);

    localparam int unsigned StageCount = 2 * CYCLE_COUNT;

    xtea_pkg::t_key   r_key;
    xtea_pkg::t_stage w_stage [StageCount+1];
    xtea_pkg::t_stage r_out;
    xtea_pkg::t_stage n_out;
    xtea_pkg::t_stage r_skid;
    xtea_pkg::t_stage n_skid;

    logic w_en;
    logic w_take;
    logic w_deliver;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_en    = !r_skid.valid;
    assign o_stall = r_skid.valid;

    assign w_stage[0].valid  = i_valid;
    assign w_stage[0].op     = i_op;
    assign w_stage[0].first  = i_block_first;
    assign w_stage[0].second = i_block_second;

    for (genvar g = 0; g < StageCount; g++) begin : g_stage
        xtea_stage #(
            .STEP        (g),
            .CYCLE_COUNT (CYCLE_COUNT)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_take    = r_out.valid && !i_stall;
    assign w_deliver = w_stage[StageCount].valid && w_en;

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (w_take || !r_out.valid) begin
            if (r_skid.valid) begin
                n_out        = r_skid;
                n_skid.valid = 1'b0;
            end else if (w_deliver) begin
                n_out = w_stage[StageCount];
            end else begin
                n_out.valid = 1'b0;
            end
        end else if (w_deliver) begin
            n_skid = w_stage[StageCount];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out  <= n_out;
            r_skid <= n_skid;
        end
    end

    assign o_valid         = r_out.valid;
    assign o_result_first  = r_out.first;
    assign o_result_second = r_out.second;

`ifndef SYNTH
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_out.valid)
        else $error("skid entry held without output entry");

    a_deliver_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deliver |=> r_out.valid)
        else $error("pipeline result dropped at output");

    a_skid_fill_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deliver && r_out.valid && i_stall) |=> (r_skid.valid && r_out.valid))
        else $error("stalled result not moved to skid entry");
`endif

endmodule

@@ sim/xtea_block_cipher_checker.sv @@
// Result checker for xtea_block_cipher: watches key writes and both transfer channels,
// predicts each ciphered block and compares it with the block's output in order.
// Depends on xtea_pkg.
module xtea_block_cipher_checker #(
    parameter int unsigned ROUNDS = xtea_pkg::CycleCount
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [xtea_pkg::KeyIdxW-1:0] i_cfg_index,
    input  logic [xtea_pkg::WordW-1:0]   i_cfg_data,

    input  logic                         i_blk_valid,
    input  logic                         i_blk_stall,
    input  logic                         i_op,
    input  logic [xtea_pkg::WordW-1:0]   i_block_first,
    input  logic [xtea_pkg::WordW-1:0]   i_block_second,

    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic [xtea_pkg::WordW-1:0]   i_result_first,
    input  logic [xtea_pkg::WordW-1:0]   i_result_second,

    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } t_block;

    xtea_pkg::t_key key_words;
    t_block         expected_blocks[$];
    int unsigned    fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic t_block xtea_crypt(input logic op, input t_block blk,
                                          input xtea_pkg::t_key key);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        t_block      res;
        v0 = blk.first;
        v1 = blk.second;
        if (op == xtea_pkg::OpEncrypt) begin
            sum = '0;
            for (int n = 0; n < ROUNDS; n++) begin
                v0  = v0 + ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
                sum = sum + xtea_pkg::XteaDelta;
                v1  = v1 + ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
            end
        end else begin
            sum = xtea_pkg::XteaDelta * 32'(ROUNDS);
            for (int n = 0; n < ROUNDS; n++) begin
                v1  = v1 - ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
                sum = sum - xtea_pkg::XteaDelta;
                v0  = v0 - ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
            end
        end
        res.first  = v0;
        res.second = v1;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("xtea check: %s", msg);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_block blk_in;
        t_block got;
        t_block want;
        if (!i_rst_n) begin
            key_words = '0;
            expected_blocks.delete();
        end else begin
            if (i_cfg_we) key_words[i_cfg_index] = i_cfg_data;
            if (i_blk_valid && !i_blk_stall) begin
                blk_in.first  = i_block_first;
                blk_in.second = i_block_second;
                expected_blocks.push_back(xtea_crypt(i_op, blk_in, key_words));
            end
            if (i_res_valid && !i_res_stall) begin
                got.first  = i_result_first;
                got.second = i_result_second;
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h %h", got.first, got.second));
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.first !== want.first)
                        report_mismatch($sformatf("result_first %h, want %h",
                                                  got.first, want.first));
                    if (got.second !== want.second)
                        report_mismatch($sformatf("result_second %h, want %h",
                                                  got.second, want.second));
                end
            end
        end
        o_pending <= expected_blocks.size();
    end

endmodule

@@ sim/xtea_block_cipher_tb.sv @@
// Testbench top for xtea_block_cipher: clock, reset, key programming, block stimulus
// under several idle/stall mixes, watchdog and verdict.
// Depends on xtea_pkg, xtea_block_cipher and xtea_block_cipher_checker.
module xtea_block_cipher_tb;

    localparam int unsigned ROUNDS         = xtea_pkg::CycleCount;
    localparam int          HOLD_CYCLES    = 500;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 2 * ROUNDS + 8;
    localparam int          PHASE_ITEMS    = 240;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = '0;
    logic [31:0] i_cfg_data     = '0;
    logic        i_valid        = 1'b0;
    logic        i_op           = xtea_pkg::OpEncrypt;
    logic [31:0] i_block_first  = '0;
    logic [31:0] i_block_second = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_result_first;
    logic [31:0] o_result_second;

    int unsigned fail_count;
    int unsigned pending_blocks;

    int tx_pct   = 0;
    int rx_pct   = 0;
    int hold_req = 0;
    int quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    xtea_block_cipher #(
        .CYCLE_COUNT (ROUNDS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_block_first   (i_block_first),
        .i_block_second  (i_block_second),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_first  (o_result_first),
        .o_result_second (o_result_second)
    );

    xtea_block_cipher_checker #(
        .ROUNDS (ROUNDS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_blk_valid     (i_valid),
        .i_blk_stall     (o_stall),
        .i_op            (i_op),
        .i_block_first   (i_block_first),
        .i_block_second  (i_block_second),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_result_first  (o_result_first),
        .i_result_second (o_result_second),
        .o_fail_count    (fail_count),
        .o_pending       (pending_blocks)
    );

    // receiver: random stall, or a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left--;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** xtea_block_cipher: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            2:       w = 32'h1 << $urandom_range(31);
            3:       w = ~(32'h1 << $urandom_range(31));
            default: w = $urandom();
        endcase
        return w;
    endfunction

    task automatic send_block(input logic op, input logic [31:0] first,
                              input logic [31:0] second);
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_block_first  <= first;
        i_block_second <= second;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_blocks != 0);
    endtask

    task automatic program_keys(input xtea_pkg::t_key key, input logic [3:0] mask);
        for (int i = 0; i < xtea_pkg::KeyWords; i++) begin
            if (mask[i]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= 2'(i);
                i_cfg_data  <= key[i];
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_corners();
        logic [31:0] corner_a [8] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        logic [31:0] corner_b [8] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h8000_0000};
        for (int i = 0; i < 8; i++)
            send_block((i % 2) ? xtea_pkg::OpDecrypt : xtea_pkg::OpEncrypt,
                       corner_a[i], corner_b[i]);
    endtask

    task automatic run_random(input int n, input int txp, input int rxp,
                              input int hold_at, input int pause_at);
        tx_pct = txp;
        rx_pct <= rxp;
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_req <= hold_req + 1;
            if (k == pause_at) wait_drained();
            send_block($urandom_range(1) ? xtea_pkg::OpDecrypt : xtea_pkg::OpEncrypt,
                       pick_word(), pick_word());
        end
    endtask

    initial begin
        xtea_pkg::t_key key;
        logic [3:0]     mask;
        int             tx_mode [4] = '{0, 60, 0, 28};
        int             rx_mode [4] = '{0, 0, 60, 28};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key words still at their reset value of zero
        run_corners();

        wait_drained();
        program_keys('1, 4'hF);
        run_corners();

        wait_drained();
        key = {32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        program_keys(key, 4'hF);
        send_block(xtea_pkg::OpEncrypt, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(xtea_pkg::OpDecrypt, 32'h0123_4567, 32'h89AB_CDEF);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            for (int j = 0; j < xtea_pkg::KeyWords; j++) key[j] = pick_word();
            mask = (p < 4) ? 4'hF : 4'($urandom_range(1, 15));
            program_keys(key, mask);
            run_random(PHASE_ITEMS, tx_mode[p % 4], rx_mode[p % 4],
                       (p % 4 == 0) ? 40 : -1, (p == 1) ? 120 : -1);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** xtea_block_cipher: PASSED **");
        else
            $display("** xtea_block_cipher: FAILED **");
        $finish;
    end

endmodule
